### sv/wav_header_parser_assert.svh
`ifndef WAV_HEADER_PARSER_ASSERT_SVH
`define WAV_HEADER_PARSER_ASSERT_SVH

// Checks sampled on clk_i; the first form is held off while rst_ni is low.
`ifndef ASSERT_OFF
`define WHP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define WHP_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define WHP_ASSERT(name, prop, msg)
`define WHP_ASSERT_RST(name, prop, msg)
`endif

`endif

### sv/whp_pkg.sv
`default_nettype none

package whp_pkg;

  localparam int unsigned HEADER_WINDOW = 512;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [31:0] POS_MAX  = 32'hFFFF_FFFF;
  localparam logic [31:0] POS_FIRST_CHUNK = 32'd12;

  typedef enum logic [2:0] {
    WHP_OK        = 3'd0,
    WHP_BAD_MAGIC = 3'd1,
    WHP_NO_FMT    = 3'd2,
    WHP_NOT_PCM   = 3'd3,
    WHP_NOT_8BIT  = 3'd4,
    WHP_NO_DATA   = 3'd5
  } whp_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } whp_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] data_offset;
    logic [31:0] data_length;
  } whp_out_t;

  // Byte idx of a four-character tag, first character in the top byte.
  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
    logic [4:0] sh;
    sh = {~idx, 3'b000};
    return tag[sh +: 8];
  endfunction

endpackage

`default_nettype wire

### sv/whp_step.sv
`default_nettype none

module whp_step import whp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire whp_in_t  item_i,
  output logic          res_valid_o,
  output whp_out_t      res_o
);

  logic [31:0] pos_q, pos_d;
  logic [31:0] ncs_q, ncs_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] size_q, size_d;
  logic        fmt_found_q, fmt_found_d;
  logic [31:0] fmt_body_q, fmt_body_d;
  logic [15:0] ftag_q, ftag_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic        decided_q, decided_d;

  logic [7:0]  b;
  logic        magic_bad;
  logic        live;
  logic [32:0] d_diff;
  logic [32:0] rel_diff;
  logic        in_hdr;
  logic [2:0]  rel;
  logic        hdr_done;
  logic        data_hit;
  logic        fmt_hit;
  logic [33:0] nxt;
  logic [31:0] pos_inc;
  whp_status_e fmt_st;
  whp_status_e st;

  assign b       = item_i.data_byte;
  assign pos_inc = pos_q + 32'd1;

  always_comb begin
    magic_bad = 1'b0;
    if (!decided_q) begin
      if (pos_q < 32'd4 && b != tag_byte(TAG_RIFF, pos_q[1:0])) begin
        magic_bad = 1'b1;
      end else if (pos_q >= 32'd8 && pos_q < 32'd12 &&
                   b != tag_byte(TAG_WAVE, pos_q[1:0])) begin
        magic_bad = 1'b1;
      end
    end
  end

  assign live     = !decided_q && !magic_bad;
  assign d_diff   = {1'b0, pos_q} - {1'b0, fmt_body_q};
  assign rel_diff = {1'b0, pos_q} - {1'b0, ncs_q};
  assign in_hdr   = live && (ncs_q != '0) && !rel_diff[32] && (rel_diff[31:3] == '0);
  assign rel      = rel_diff[2:0];
  assign hdr_done = in_hdr && (rel == 3'd7);
  assign data_hit = hdr_done && (tag_q == TAG_DATA);
  assign fmt_hit  = hdr_done && (tag_q == TAG_FMT) && (pos_q < 32'(HEADER_WINDOW));

  always_comb begin
    ftag_d      = ftag_q;
    chan_d      = chan_q;
    rate_d      = rate_q;
    bits_d      = bits_q;
    fmt_found_d = fmt_found_q;
    fmt_body_d  = fmt_body_q;
    tag_d       = tag_q;
    size_d      = size_q;
    nxt         = '0;

    // fmt body bytes land wherever they sit, even inside later chunks
    if (live && fmt_found_q && !d_diff[32] && d_diff[31:4] == '0) begin
      case (d_diff[3:0])
        4'd0:   ftag_d[7:0]   = b;
        4'd1:   ftag_d[15:8]  = b;
        4'd2:   chan_d[7:0]   = b;
        4'd3:   chan_d[15:8]  = b;
        4'd4:   rate_d[7:0]   = b;
        4'd5:   rate_d[15:8]  = b;
        4'd6:   rate_d[23:16] = b;
        4'd7:   rate_d[31:24] = b;
        4'd14:  bits_d[7:0]   = b;
        4'd15:  bits_d[15:8]  = b;
        default: ;
      endcase
    end

    if (in_hdr) begin
      if (!rel[2]) begin
        tag_d = {tag_q[23:0], b};
      end else begin
        size_d = {b, size_q[31:8]};
      end
    end

    if (fmt_hit) begin
      fmt_found_d = 1'b1;
      fmt_body_d  = pos_inc;
      ftag_d      = '0;
      chan_d      = '0;
      rate_d      = '0;
      bits_d      = '0;
    end

    // next header after body plus pad byte; past 32 bits the chain is lost
    nxt = {2'b00, pos_q} + {2'b00, size_d} + (size_d[0] ? 34'd2 : 34'd1);
  end

  always_comb begin
    if (!fmt_found_d) begin
      fmt_st = WHP_NO_FMT;
    end else if (ftag_d != 16'd1) begin
      fmt_st = WHP_NOT_PCM;
    end else if (bits_d != 16'd8) begin
      fmt_st = WHP_NOT_8BIT;
    end else begin
      fmt_st = WHP_OK;
    end
  end

  always_comb begin
    res_valid_o = !decided_q && (magic_bad || data_hit || item_i.last_byte);
    if (magic_bad) begin
      st = WHP_BAD_MAGIC;
    end else if (data_hit) begin
      st = (fmt_st == WHP_OK && pos_q == POS_MAX) ? WHP_NO_DATA : fmt_st;
    end else if (pos_q < 32'd11) begin
      st = WHP_BAD_MAGIC;
    end else begin
      st = (fmt_st == WHP_OK) ? WHP_NO_DATA : fmt_st;
    end

    res_o        = '0;
    res_o.status = st;
    if (st == WHP_OK) begin
      res_o.channel_count = chan_d;
      res_o.sample_rate   = rate_d;
      res_o.data_offset   = pos_inc;
      res_o.data_length   = size_d;
    end
  end

  always_comb begin
    decided_d = decided_q || res_valid_o;
    ncs_d     = ncs_q;
    pos_d     = pos_q;
    if (hdr_done && !data_hit) begin
      ncs_d = (nxt[33:32] != 2'b00) ? '0 : nxt[31:0];
    end
    // saturate the position and drop out of the chain
    if (pos_q == POS_MAX) begin
      ncs_d = '0;
    end else begin
      pos_d = pos_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      ncs_q       <= POS_FIRST_CHUNK;
      tag_q       <= '0;
      size_q      <= '0;
      fmt_found_q <= 1'b0;
      fmt_body_q  <= '0;
      ftag_q      <= '0;
      chan_q      <= '0;
      rate_q      <= '0;
      bits_q      <= '0;
      decided_q   <= 1'b0;
    end else if (step_i) begin
      if (item_i.last_byte) begin
        // rearm for the next file
        pos_q       <= '0;
        ncs_q       <= POS_FIRST_CHUNK;
        tag_q       <= '0;
        size_q      <= '0;
        fmt_found_q <= 1'b0;
        fmt_body_q  <= '0;
        ftag_q      <= '0;
        chan_q      <= '0;
        rate_q      <= '0;
        bits_q      <= '0;
        decided_q   <= 1'b0;
      end else begin
        pos_q       <= pos_d;
        ncs_q       <= ncs_d;
        tag_q       <= tag_d;
        size_q      <= size_d;
        fmt_found_q <= fmt_found_d;
        fmt_body_q  <= fmt_body_d;
        ftag_q      <= ftag_d;
        chan_q      <= chan_d;
        rate_q      <= rate_d;
        bits_q      <= bits_d;
        decided_q   <= decided_d;
      end
    end
  end

endmodule

`default_nettype wire

### sv/wav_header_parser.sv
// Flow: a transferred byte waits in the input register and is parsed when the result
//   register is free or draining; its result, if any, is captured in the result register.
// Throughput: one byte per cycle while the receiver does not stall, set by the
//   single-pass parse between the input register and the result register.
// Reset: asynchronous, active low; clears the parse state and both valid flags.
`default_nettype none

`include "wav_header_parser_assert.svh"

module wav_header_parser import whp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire whp_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output whp_out_t     out_data_o
);

  logic     in_vld_q;
  whp_in_t  in_item_q;
  logic     out_vld_q;
  whp_out_t out_data_q;
  logic     go;
  logic     res_valid;
  whp_out_t res;

  // parse when the result register is free or draining this cycle
  assign go         = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !go;

  whp_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (go),
    .item_i      (in_item_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (go && res_valid) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

  `WHP_ASSERT_RST(a_reset_idle, !rst_ni |-> !out_valid_o, "result valid during reset")
  `WHP_ASSERT(a_held_item, in_vld_q && in_stall_o |=> in_vld_q, "held byte lost")
  `WHP_ASSERT(a_status_range, out_valid_o |-> out_data_o.status <= WHP_NO_DATA, "bad status")
  `WHP_ASSERT(a_err_zero, out_valid_o && out_data_o.status != WHP_OK |-> out_data_o.data_offset == '0 && out_data_o.data_length == '0 && out_data_o.sample_rate == '0 && out_data_o.channel_count == '0, "error result carries fields")
  `WHP_ASSERT(a_ok_offset, out_valid_o && out_data_o.status == WHP_OK |-> out_data_o.data_offset >= 32'd20, "data offset inside header")

endmodule

`default_nettype wire

### tb/sv/wav_header_parser_tb.sv
`timescale 1ns / 1ps

module wav_header_parser_tb;
  import whp_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  whp_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  whp_out_t out_data_o;

  wav_header_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  typedef struct {
    logic [95:0]  text;
    int unsigned  len;
    bit           typed;
    whp_status_e  st;
  } file_row_t;

  // Parser state tracked alongside the block
  logic [31:0] p_pos, p_next, p_tag, p_size, p_fmt_body, p_rate;
  logic [15:0] p_ftag, p_chan, p_bits;
  logic        p_fmt_found, p_decided;

  whp_out_t    pending_reports[$];
  logic [7:0]  file_bytes[$];
  int unsigned fresh_bytes;
  int unsigned mismatches;
  bit          calm;
  bit          hold_out_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic parser_reset();
    p_pos       = '0;
    p_next      = POS_FIRST_CHUNK;
    p_tag       = '0;
    p_size      = '0;
    p_fmt_found = 1'b0;
    p_fmt_body  = '0;
    p_ftag      = '0;
    p_chan      = '0;
    p_rate      = '0;
    p_bits      = '0;
    p_decided   = 1'b0;
  endtask

  function automatic whp_status_e fmt_verdict();
    if (!p_fmt_found) return WHP_NO_FMT;
    if (p_ftag != 16'd1) return WHP_NOT_PCM;
    if (p_bits != 16'd8) return WHP_NOT_8BIT;
    return WHP_OK;
  endfunction

  function automatic whp_out_t header_report(input whp_status_e st, input logic [31:0] off,
                                             input logic [31:0] len);
    whp_out_t r;
    r = '0;
    r.status = st;
    if (st == WHP_OK) begin
      r.channel_count = p_chan;
      r.sample_rate   = p_rate;
      r.data_offset   = off;
      r.data_length   = len;
    end
    p_decided = 1'b1;
    return r;
  endfunction

  task automatic parse_byte(input whp_in_t it, output bit got, output whp_out_t res);
    logic [31:0] pos, d, rel;
    logic [33:0] nxt;
    logic [7:0]  b;
    whp_status_e st;
    b   = it.data_byte;
    pos = p_pos;
    got = 1'b0;
    res = '0;
    if (!p_decided) begin
      if ((pos < 4 && b != TAG_RIFF[8*(3 - pos[1:0]) +: 8]) ||
          (pos >= 8 && pos < 12 && b != TAG_WAVE[8*(3 - pos[1:0]) +: 8])) begin
        res = header_report(WHP_BAD_MAGIC, '0, '0);
        got = 1'b1;
      end
    end
    if (!p_decided) begin
      // fmt body fields come from whatever bytes land at their offsets
      if (p_fmt_found && pos >= p_fmt_body) begin
        d = pos - p_fmt_body;
        if (d < 2) p_ftag[8*d[0] +: 8] = b;
        else if (d < 4) p_chan[8*d[0] +: 8] = b;
        else if (d < 8) p_rate[8*d[1:0] +: 8] = b;
        else if (d == 14 || d == 15) p_bits[8*d[0] +: 8] = b;
      end
      if (p_next != 0 && pos >= p_next && (pos - p_next) < 32'd8) begin
        rel = pos - p_next;
        if (rel < 4) begin
          p_tag = {p_tag[23:0], b};
        end else begin
          p_size = {b, p_size[31:8]};
          if (rel == 7) begin
            if (p_tag == TAG_DATA) begin
              st = fmt_verdict();
              if (st == WHP_OK && pos == POS_MAX) st = WHP_NO_DATA;
              res = header_report(st, pos + 32'd1, p_size);
              got = 1'b1;
            end else if (p_tag == TAG_FMT && pos < HEADER_WINDOW) begin
              p_fmt_found = 1'b1;
              p_fmt_body  = pos + 32'd1;
              p_ftag      = '0;
              p_chan      = '0;
              p_rate      = '0;
              p_bits      = '0;
            end
            if (!p_decided) begin
              nxt    = {2'b00, pos} + 34'd1 + {2'b00, p_size} + {33'd0, p_size[0]};
              // lose the chain when the next header would sit past 32 bits
              p_next = (nxt[33:32] != 2'b00) ? '0 : nxt[31:0];
            end
          end
        end
      end
    end
    if (it.last_byte) begin
      if (!p_decided) begin
        if (pos < 11) st = WHP_BAD_MAGIC;
        else begin
          st = fmt_verdict();
          if (st == WHP_OK) st = WHP_NO_DATA;
        end
        res = header_report(st, '0, '0);
        got = 1'b1;
      end
      parser_reset();
    end else if (pos == POS_MAX) begin
      p_next = '0;
    end else begin
      p_pos = pos + 32'd1;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input whp_in_t it, input bit typed, input whp_status_e typed_st);
    bit       got;
    whp_out_t res;
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (!p_decided) fresh_bytes++;
    parse_byte(it, got, res);
    if (got) begin
      if (typed) begin
        res        = '0;
        res.status = typed_st;
      end
      pending_reports.push_back(res);
    end
    @(negedge clk_i);
  endtask

  task automatic send_file();
    whp_in_t it;
    foreach (file_bytes[k]) begin
      it.data_byte = file_bytes[k];
      it.last_byte = (k == file_bytes.size() - 1);
      send_byte(it, 1'b0, WHP_OK);
    end
  endtask

  task automatic add_tag(input logic [31:0] tag);
    for (int k = 3; k >= 0; k--) file_bytes.push_back(tag[8*k +: 8]);
  endtask

  task automatic add_word(input logic [31:0] v);
    for (int k = 0; k < 4; k++) file_bytes.push_back(v[8*k +: 8]);
  endtask

  task automatic add_chunk(input logic [31:0] tag, input logic [31:0] sz, input int unsigned fill);
    add_tag(tag);
    add_word(sz);
    repeat (fill) file_bytes.push_back(8'($urandom));
  endtask

  task automatic add_fmt();
    logic [127:0] body;
    int unsigned  sz, pick;
    body = {$urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 9) < 8) body[15:0] = 16'd1;
    if ($urandom_range(0, 9) < 6) body[31:16] = 16'($urandom_range(1, 2));
    if ($urandom_range(0, 9) < 8) body[127:112] = 16'd8;
    pick = $urandom_range(0, 19);
    sz = (pick < 14) ? 16 : (pick < 17) ? $urandom_range(17, 21) : $urandom_range(0, 15);
    add_tag(TAG_FMT);
    add_word(sz);
    for (int k = 0; k < sz; k++)
      file_bytes.push_back((k < 16) ? body[8*k +: 8] : 8'($urandom));
    if (sz % 2) file_bytes.push_back(8'($urandom));
  endtask

  task automatic add_data();
    int unsigned pick;
    logic [31:0] sz;
    pick = $urandom_range(0, 19);
    sz = (pick < 14) ? $urandom_range(0, 64) : (pick < 17) ? $urandom :
         32'hFFFF_FFF0 | $urandom_range(0, 15);
    add_chunk(TAG_DATA, sz, $urandom_range(0, 4));
  endtask

  task automatic add_random_chunk();
    int unsigned pick, sz;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      add_fmt();
    end else if (pick < 8) begin
      sz = $urandom_range(0, 12);
      add_chunk($urandom, sz, sz + sz % 2);
    end else if (pick < 9) begin
      add_data();
    end else begin
      // huge size: lose the chain, or push the next header far away
      add_chunk($urandom, 32'hFFFF_FF00 | $urandom_range(0, 255), $urandom_range(0, 3));
    end
  endtask

  task automatic build_file();
    int unsigned kind, n, sz, idx;
    file_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      if ($urandom_range(0, 1)) add_tag(TAG_RIFF);
      repeat ($urandom_range(1, 20)) file_bytes.push_back(8'($urandom));
      return;
    end
    add_tag(TAG_RIFF);
    add_word($urandom);
    add_tag(TAG_WAVE);
    if (kind < 18) begin
      n = $urandom_range(1, 11);
      while (file_bytes.size() > n) void'(file_bytes.pop_back());
      return;
    end
    if (kind < 21) begin
      // filler that lands the next fmt header on either side of the window edge
      if ($urandom_range(0, 1)) add_fmt();
      sz = $urandom_range(470, 490);
      add_chunk($urandom, sz, sz + sz % 2);
      add_fmt();
      add_data();
    end else begin
      repeat ($urandom_range(0, 3)) add_random_chunk();
      if ($urandom_range(0, 9) < 7) add_data();
    end
    if (kind >= 80 && kind < 88) begin
      n = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > n) void'(file_bytes.pop_back());
    end else if (kind >= 88) begin
      idx = $urandom_range(0, file_bytes.size() - 1);
      file_bytes[idx] = file_bytes[idx] ^ (8'd1 << $urandom_range(0, 7));
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    whp_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_data_o);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", 32'(want.status), 32'(out_data_o.status));
        check_field("channel_count", 32'(want.channel_count), 32'(out_data_o.channel_count));
        check_field("sample_rate", want.sample_rate, out_data_o.sample_rate);
        check_field("data_offset", want.data_offset, out_data_o.data_offset);
        check_field("data_length", want.data_length, out_data_o.data_length);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        hold_left    = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 10);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else if (++quiet >= 4000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    file_row_t directed_files[4];
    whp_in_t   it;
    bit        hold_done, drain_done;
    directed_files[0] = '{text: {8'hFF, 88'h0}, len: 1, typed: 1'b1, st: WHP_BAD_MAGIC};
    directed_files[1] = '{text: {TAG_RIFF[31:8], 72'h0}, len: 3, typed: 1'b1,
                          st: WHP_BAD_MAGIC};
    directed_files[2] = '{text: {TAG_RIFF, 32'h0, TAG_WAVE[31:8], 8'h00}, len: 12,
                          typed: 1'b1, st: WHP_BAD_MAGIC};
    directed_files[3] = '{text: {TAG_RIFF, 32'hFFFF_FFFF, TAG_WAVE}, len: 12, typed: 1'b1,
                          st: WHP_NO_FMT};
    hold_done     = 1'b0;
    drain_done    = 1'b0;
    calm          = 1'b0;
    hold_out_req  = 1'b0;
    fresh_bytes   = 0;
    mismatches    = 0;
    parser_reset();
    rst_ni     = 1'b1;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    // assert reset after time zero so the block sees a clean falling edge
    #1 rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_files[f]) begin
      for (int k = 0; k < directed_files[f].len; k++) begin
        it.data_byte = directed_files[f].text[95 - 8*k -: 8];
        it.last_byte = (k == directed_files[f].len - 1);
        send_byte(it, directed_files[f].typed, directed_files[f].st);
      end
    end

    while (fresh_bytes < 1500) begin
      calm = (fresh_bytes >= 600 && fresh_bytes < 900);
      if (!hold_done && fresh_bytes >= 300) begin
        // one-byte files each give a result: fill the block behind a held receiver
        hold_done    = 1'b1;
        hold_out_req = 1'b1;
        repeat (20) begin
          file_bytes.delete();
          file_bytes.push_back(8'($urandom));
          send_file();
        end
      end
      if (!drain_done && fresh_bytes >= 1100) begin
        drain_done = 1'b1;
        in_valid_i <= 1'b0;
        wait (pending_reports.size() == 0);
        @(negedge clk_i);
      end
      build_file();
      send_file();
    end

    in_valid_i <= 1'b0;
    wait (pending_reports.size() == 0);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_reports.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/whp_pkg.sv
sv/whp_step.sv
sv/wav_header_parser.sv
tb/sv/wav_header_parser_tb.sv
